// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define APU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define APU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/apu_pkg.sv =====
package apu_pkg;

  localparam int unsigned MemDepth   = 65536;
  localparam int unsigned AddrW      = $clog2(MemDepth);
  localparam int unsigned WordW      = 32;
  localparam int unsigned DivStages  = WordW;
  localparam int unsigned SqrtStages = 28;
  localparam int unsigned RadicandW  = 2 * SqrtStages;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegLearningRate = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBetaMomentum = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBetaRms      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEpsilon      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWeightDecay  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGradUnscale  = 3'd5;

  localparam logic [23:0] LearningRateRst = 24'd1677;
  localparam logic [15:0] BetaMomentumRst = 16'd58982;
  localparam logic [15:0] BetaRmsRst      = 16'd65470;
  localparam logic [23:0] EpsilonRst      = 24'd1;
  localparam logic [23:0] WeightDecayRst  = 24'd0;
  localparam logic [31:0] GradUnscaleRst  = 32'h8000_0000;

  localparam logic signed [31:0] MaxS32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinS32 = 32'sh8000_0000;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [63:0]      wr_data;
  } mem_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = MaxS32;
    end else if (x < 64'shFFFF_FFFF_8000_0000) begin
      r = MinS32;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/apu_div_pipe.sv =====
module apu_div_pipe (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [apu_pkg::WordW-1:0] hi_i,
  input  logic [apu_pkg::WordW-1:0] lo_i,
  input  logic [apu_pkg::WordW-1:0] div_i,
  output logic [apu_pkg::WordW-1:0] quo_o
);
  import apu_pkg::*;

  logic [WordW-1:0] rem_q [DivStages];
  logic [WordW-1:0] lo_q  [DivStages];
  logic [WordW-1:0] div_q [DivStages];
  logic [WordW-1:0] quo_q [DivStages];
  logic [WordW-1:0] rem_d [DivStages];
  logic [WordW-1:0] lo_d  [DivStages];
  logic [WordW-1:0] div_d [DivStages];
  logic [WordW-1:0] quo_d [DivStages];

  always_comb begin
    logic [WordW-1:0] s_rem;
    logic [WordW-1:0] s_lo;
    logic [WordW-1:0] s_div;
    logic [WordW-1:0] s_quo;
    logic [WordW:0]   t;
    logic [WordW:0]   diff;
    logic             ge;
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        s_rem = hi_i;
        s_lo  = lo_i;
        s_div = div_i;
        s_quo = '0;
      end else begin
        s_rem = rem_q[k-1];
        s_lo  = lo_q[k-1];
        s_div = div_q[k-1];
        s_quo = quo_q[k-1];
      end
      t        = {s_rem, s_lo[WordW-1]};
      diff     = t - {1'b0, s_div};
      ge       = t >= {1'b0, s_div};
      rem_d[k] = ge ? diff[WordW-1:0] : t[WordW-1:0];
      lo_d[k]  = {s_lo[WordW-2:0], 1'b0};
      div_d[k] = s_div;
      quo_d[k] = {s_quo[WordW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        div_q[k] <= div_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

// ===== hdl/apu_sqrt_pipe.sv =====
module apu_sqrt_pipe (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [apu_pkg::WordW-1:0]      val_i,
  output logic [apu_pkg::SqrtStages-1:0] root_o
);
  import apu_pkg::*;

  localparam int unsigned RemW = SqrtStages + 2;

  logic [RemW-1:0]       rem_q  [SqrtStages];
  logic [RadicandW-1:0]  x_q    [SqrtStages];
  logic [SqrtStages-1:0] root_q [SqrtStages];
  logic [RemW-1:0]       rem_d  [SqrtStages];
  logic [RadicandW-1:0]  x_d    [SqrtStages];
  logic [SqrtStages-1:0] root_d [SqrtStages];

  always_comb begin
    logic [RemW-1:0]       s_rem;
    logic [RadicandW-1:0]  s_x;
    logic [SqrtStages-1:0] s_root;
    logic [RemW+1:0]       t;
    logic [RemW+1:0]       trial;
    logic [RemW+1:0]       diff;
    logic                  ge;
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_x    = {val_i, (RadicandW - WordW)'(0)};
        s_root = '0;
      end else begin
        s_rem  = rem_q[k-1];
        s_x    = x_q[k-1];
        s_root = root_q[k-1];
      end
      t         = {s_rem, s_x[RadicandW-1 -: 2]};
      trial     = {2'b00, s_root, 2'b01};
      diff      = t - trial;
      ge        = t >= trial;
      rem_d[k]  = ge ? diff[RemW-1:0] : t[RemW-1:0];
      x_d[k]    = {s_x[RadicandW-3:0], 2'b00};
      root_d[k] = {s_root[SqrtStages-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtStages; k++) begin
        rem_q[k]  <= rem_d[k];
        x_q[k]    <= x_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

// ===== hdl/apu_moment_store.sv =====
module apu_moment_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apu_pkg::mem_req_t req_i,
  output logic [63:0]       rdata_o,
  output logic              clearing_o
);
  import apu_pkg::*;

  logic [63:0]      mem_q [MemDepth];
  logic [63:0]      rdata_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [63:0]      wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(MemDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en   = req_i.wr_en;
    wr_addr = req_i.wr_addr;
    wr_data = req_i.wr_data;
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_busy_q;

endmodule

// ===== hdl/adam_param_update.sv =====
// Adam parameter update with decoupled weight decay, one element per item. The block takes
// one item per clock cycle while the result side does not stall, and returns each result in
// order. Both moments of every element live in one 65536-entry memory that is read in the
// stage before and written back by a single update stage, so items for the same element may
// follow each other back to back. The two moment quotients, the square root and the final
// quotient are each resolved one bit per pipeline stage, which sets the latency. A stall on
// the result side holds the whole pipeline. After reset the moment memory is cleared one
// entry per cycle, and no item is accepted until the clear is done; configuration writes are
// taken at any time and should only be made while no item is in flight.
module adam_param_update (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [15:0]                      element_index_i,
  input  logic signed [31:0]               gradient_i,
  input  logic signed [31:0]               param_in_i,
  input  logic                             first_of_step_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               param_out_o,
  input  logic                             cfg_we_i,
  input  logic [apu_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import apu_pkg::*;

  typedef struct packed {
    logic        mneg;
    logic        movf;
    logic        vovf;
    logic [31:0] p;
    logic [32:0] dp;
  } seg_a_t;

  typedef struct packed {
    logic [31:0] mh;
    logic [31:0] p;
    logic [32:0] dp;
  } seg_b_t;

  typedef struct packed {
    logic        qneg;
    logic        qovf;
    logic [31:0] p;
    logic [32:0] dp;
  } seg_c_t;

  function automatic logic [31:0] advance_denom(input logic [31:0] d, input logic [15:0] beta);
    logic [48:0] acc;
    logic [48:0] sh;
    acc = 49'(beta) * 49'(d) + {(17'h1_0000 - {1'b0, beta}), 32'b0};
    sh  = acc >> 16;
    return (sh > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
  endfunction

  function automatic logic [31:0] fit_quotient(input logic neg, input logic ovf,
                                               input logic [31:0] quo);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? MinS32 : MaxS32;
    end else if (neg) begin
      r = (quo > 32'h8000_0000) ? MinS32 : -$signed(quo);
    end else begin
      r = (quo > 32'h7FFF_FFFF) ? MaxS32 : $signed(quo);
    end
    return r;
  endfunction

  logic [23:0] lr_q;
  logic [15:0] beta_mom_q;
  logic [15:0] beta_rms_q;
  logic [23:0] eps_q;
  logic [23:0] decay_q;
  logic [31:0] unscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= LearningRateRst;
      beta_mom_q <= BetaMomentumRst;
      beta_rms_q <= BetaRmsRst;
      eps_q      <= EpsilonRst;
      decay_q    <= WeightDecayRst;
      unscale_q  <= GradUnscaleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLearningRate: lr_q       <= cfg_wdata_i[23:0];
        RegBetaMomentum: beta_mom_q <= cfg_wdata_i[15:0];
        RegBetaRms:      beta_rms_q <= cfg_wdata_i[15:0];
        RegEpsilon:      eps_q      <= cfg_wdata_i[23:0];
        RegWeightDecay:  decay_q    <= cfg_wdata_i[23:0];
        RegGradUnscale:  unscale_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  logic     en;
  logic     clearing;
  logic     accept;
  logic     out_valid_q;
  mem_req_t mem_req;
  logic [63:0] mem_rdata;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && !clearing;
  assign accept     = in_valid_i && in_ready_o;

  // Front stages: gradient unscale, decay product, squared gradient.
  logic                     s1_valid_q;
  logic [AddrW-1:0]         s1_idx_q;
  logic signed [31:0]       s1_grad_q;
  logic signed [31:0]       s1_p_q;
  logic                     s1_first_q;
  logic signed [63:0]       s1_prod_g;
  logic signed [55:0]       s1_prod_dp;

  assign s1_prod_g  = 64'(s1_grad_q) * 64'($signed({1'b0, unscale_q}));
  assign s1_prod_dp = 56'(s1_p_q) * 56'($signed({1'b0, decay_q}));

  logic                     s2_valid_q;
  logic [AddrW-1:0]         s2_idx_q;
  logic signed [31:0]       s2_p_q;
  logic                     s2_first_q;
  logic signed [63:0]       s2_prod_g_q;
  logic signed [55:0]       s2_prod_dp_q;
  logic signed [63:0]       s2_g_rnd;
  logic signed [31:0]       s2_g;
  logic [31:0]              s2_g_mag;
  logic [63:0]              s2_gg;
  logic signed [55:0]       s2_dp_full;

  assign s2_g_rnd   = (s2_prod_g_q + 64'sd1073741824) >>> 31;
  assign s2_g       = sat32(s2_g_rnd);
  assign s2_g_mag   = s2_g[31] ? (~s2_g + 32'd1) : s2_g;
  assign s2_gg      = 64'(s2_g_mag) * 64'(s2_g_mag);
  assign s2_dp_full = (s2_prod_dp_q + 56'sd8388608) >>> 24;

  // Moment update stage with forwarding from the item one stage ahead.
  logic                     s3_valid_q;
  logic [AddrW-1:0]         s3_idx_q;
  logic signed [31:0]       s3_p_q;
  logic                     s3_first_q;
  logic signed [31:0]       s3_g_q;
  logic [63:0]              s3_gg_q;
  logic [32:0]              s3_dp_q;

  logic                     s4_valid_q;
  logic [AddrW-1:0]         s4_idx_q;
  logic [31:0]              s4_m_q;
  logic [31:0]              s4_v_q;
  logic [31:0]              s4_d1_q;
  logic [31:0]              s4_d2_q;
  logic [31:0]              s4_p_q;
  logic [32:0]              s4_dp_q;

  logic [31:0]              d1_q;
  logic [31:0]              d2_q;

  logic                     s3_fwd;
  logic signed [31:0]       s3_m_old;
  logic [31:0]              s3_v_old;
  logic [16:0]              one_b1;
  logic [16:0]              one_b2;
  logic signed [49:0]       s3_m_acc;
  logic signed [49:0]       s3_m_rnd;
  logic signed [31:0]       s3_m_new;
  logic [63:0]              s3_gg_rnd;
  logic [31:0]              s3_g2;
  logic [48:0]              s3_v_acc;
  logic [48:0]              s3_v_sh;
  logic [31:0]              s3_v_new;
  logic [31:0]              s3_adv1;
  logic [31:0]              s3_adv2;
  logic [31:0]              s3_d1;
  logic [31:0]              s3_d2;

  assign s3_fwd   = s4_valid_q && (s4_idx_q == s3_idx_q);
  assign s3_m_old = s3_fwd ? s4_m_q : mem_rdata[63:32];
  assign s3_v_old = s3_fwd ? s4_v_q : mem_rdata[31:0];
  assign one_b1   = 17'h1_0000 - {1'b0, beta_mom_q};
  assign one_b2   = 17'h1_0000 - {1'b0, beta_rms_q};

  assign s3_m_acc = 50'($signed({1'b0, beta_mom_q})) * 50'(s3_m_old)
                  + 50'($signed({1'b0, one_b1})) * 50'(s3_g_q);
  assign s3_m_rnd = (s3_m_acc + 50'sd32768) >>> 16;
  assign s3_m_new = sat32(64'(s3_m_rnd));

  assign s3_gg_rnd = (s3_gg_q + 64'd8388608) >> 24;
  assign s3_g2     = (s3_gg_rnd > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : s3_gg_rnd[31:0];
  assign s3_v_acc  = 49'(beta_rms_q) * 49'(s3_v_old) + 49'(one_b2) * 49'(s3_g2) + 49'd32768;
  assign s3_v_sh   = s3_v_acc >> 16;
  assign s3_v_new  = (s3_v_sh > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s3_v_sh[31:0];

  assign s3_adv1 = advance_denom(d1_q, beta_mom_q);
  assign s3_adv2 = advance_denom(d2_q, beta_rms_q);
  assign s3_d1   = s3_first_q ? s3_adv1 : d1_q;
  assign s3_d2   = s3_first_q ? s3_adv2 : d2_q;

  always_comb begin
    mem_req.rd_en   = en;
    mem_req.rd_addr = s2_idx_q;
    mem_req.wr_en   = en && s3_valid_q;
    mem_req.wr_addr = s3_idx_q;
    mem_req.wr_data = {s3_m_new, s3_v_new};
  end

  apu_moment_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (mem_rdata),
    .clearing_o (clearing)
  );

  // Divider inputs for the bias-corrected moments.
  logic [31:0] s4_d1e;
  logic [31:0] s4_d2e;
  logic        s4_mneg;
  logic [31:0] s4_mmag;
  logic        s4_movf;
  logic        s4_vovf;
  logic [31:0] quo_m;
  logic [31:0] quo_v;

  assign s4_d1e  = (s4_d1_q == 32'd0) ? 32'd1 : s4_d1_q;
  assign s4_d2e  = (s4_d2_q == 32'd0) ? 32'd1 : s4_d2_q;
  assign s4_mneg = s4_m_q[31];
  assign s4_mmag = s4_mneg ? (~s4_m_q + 32'd1) : s4_m_q;
  assign s4_movf = s4_mmag >= s4_d1e;
  assign s4_vovf = s4_v_q >= s4_d2e;

  apu_div_pipe u_div_m (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  (s4_mmag),
    .lo_i  (32'd0),
    .div_i (s4_d1e),
    .quo_o (quo_m)
  );

  apu_div_pipe u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  (s4_v_q),
    .lo_i  (32'd0),
    .div_i (s4_d2e),
    .quo_o (quo_v)
  );

  logic [DivStages-1:0]  a_vld_q;
  seg_a_t                a_q [DivStages];
  logic [31:0]           a_mh;
  logic [31:0]           a_vh;
  logic [SqrtStages-1:0] root;

  assign a_mh = fit_quotient(a_q[DivStages-1].mneg, a_q[DivStages-1].movf, quo_m);
  assign a_vh = a_q[DivStages-1].vovf ? 32'hFFFF_FFFF : quo_v;

  apu_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (a_vh),
    .root_o (root)
  );

  logic [SqrtStages-1:0] b_vld_q;
  seg_b_t                b_q [SqrtStages];
  logic [28:0]           b_den_sum;
  logic [28:0]           b_den;
  logic                  b_neg;
  logic [31:0]           b_mag;
  logic                  b_qovf;
  logic [31:0]           quo_q_out;

  assign b_den_sum = {1'b0, root} + {5'b0, eps_q};
  assign b_den     = (b_den_sum == 29'd0) ? 29'd1 : b_den_sum;
  assign b_neg     = b_q[SqrtStages-1].mh[31];
  assign b_mag     = b_neg ? (~b_q[SqrtStages-1].mh + 32'd1) : b_q[SqrtStages-1].mh;
  assign b_qovf    = {5'b0, b_mag} >= {b_den, 8'b0};

  apu_div_pipe u_div_q (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  ({8'b0, b_mag[31:8]}),
    .lo_i  ({b_mag[7:0], 24'b0}),
    .div_i ({3'b0, b_den}),
    .quo_o (quo_q_out)
  );

  logic [DivStages-1:0] c_vld_q;
  seg_c_t               c_q [DivStages];
  logic signed [31:0]   c_q_val;
  logic signed [33:0]   c_sum;

  assign c_q_val = fit_quotient(c_q[DivStages-1].qneg, c_q[DivStages-1].qovf, quo_q_out);
  assign c_sum   = 34'(c_q_val) + 34'($signed(c_q[DivStages-1].dp));

  // Final step: scale by the learning rate and subtract from the parameter.
  logic                f1_valid_q;
  logic signed [33:0]  f1_sum_q;
  logic signed [31:0]  f1_p_q;
  logic signed [57:0]  f1_prod;
  logic                f2_valid_q;
  logic signed [57:0]  f2_prod_q;
  logic signed [31:0]  f2_p_q;
  logic signed [57:0]  f2_upd;
  logic signed [31:0]  f2_res;
  logic signed [31:0]  param_out_q;

  assign f1_prod = 58'($signed({1'b0, lr_q})) * 58'(f1_sum_q);
  assign f2_upd  = (f2_prod_q + 58'sd8388608) >>> 24;
  assign f2_res  = sat32(64'(f2_p_q) - 64'(f2_upd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      a_vld_q     <= '0;
      b_vld_q     <= '0;
      c_vld_q     <= '0;
      f1_valid_q  <= 1'b0;
      f2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else if (en) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      a_vld_q     <= {a_vld_q[DivStages-2:0], s4_valid_q};
      b_vld_q     <= {b_vld_q[SqrtStages-2:0], a_vld_q[DivStages-1]};
      c_vld_q     <= {c_vld_q[DivStages-2:0], b_vld_q[SqrtStages-1]};
      f1_valid_q  <= c_vld_q[DivStages-1];
      f2_valid_q  <= f1_valid_q;
      out_valid_q <= f2_valid_q;
      if (s3_valid_q && s3_first_q) begin
        d1_q <= s3_adv1;
        d2_q <= s3_adv2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q     <= element_index_i;
      s1_grad_q    <= gradient_i;
      s1_p_q       <= param_in_i;
      s1_first_q   <= first_of_step_i;
      s2_idx_q     <= s1_idx_q;
      s2_p_q       <= s1_p_q;
      s2_first_q   <= s1_first_q;
      s2_prod_g_q  <= s1_prod_g;
      s2_prod_dp_q <= s1_prod_dp;
      s3_idx_q     <= s2_idx_q;
      s3_p_q       <= s2_p_q;
      s3_first_q   <= s2_first_q;
      s3_g_q       <= s2_g;
      s3_gg_q      <= s2_gg;
      s3_dp_q      <= s2_dp_full[32:0];
      s4_idx_q     <= s3_idx_q;
      s4_m_q       <= s3_m_new;
      s4_v_q       <= s3_v_new;
      s4_d1_q      <= s3_d1;
      s4_d2_q      <= s3_d2;
      s4_p_q       <= s3_p_q;
      s4_dp_q      <= s3_dp_q;
      a_q[0]       <= '{mneg: s4_mneg, movf: s4_movf, vovf: s4_vovf,
                        p: s4_p_q, dp: s4_dp_q};
      for (int k = 1; k < DivStages; k++) begin
        a_q[k] <= a_q[k-1];
      end
      b_q[0]       <= '{mh: a_mh, p: a_q[DivStages-1].p, dp: a_q[DivStages-1].dp};
      for (int k = 1; k < SqrtStages; k++) begin
        b_q[k] <= b_q[k-1];
      end
      c_q[0]       <= '{qneg: b_neg, qovf: b_qovf,
                        p: b_q[SqrtStages-1].p, dp: b_q[SqrtStages-1].dp};
      for (int k = 1; k < DivStages; k++) begin
        c_q[k] <= c_q[k-1];
      end
      f1_sum_q     <= c_sum;
      f1_p_q       <= c_q[DivStages-1].p;
      f2_prod_q    <= f1_prod;
      f2_p_q       <= f1_p_q;
      param_out_q  <= f2_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign param_out_o = param_out_q;

endmodule

// ===== hdl/apu_checker.sv =====
`include "assert_macros.svh"

module apu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] param_out_o
);

  `APU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result item dropped while stalled")
  `APU_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(param_out_o), "result item changed while stalled")
  `APU_ASSERT_ALWAYS(a_clear_blocks_input, clk_i, !rst_ni |=> !in_ready_o, "item taken while memory clear is pending")
  `APU_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |=> !out_valid_o, "result item shown right after reset")

endmodule

bind adam_param_update apu_checker u_apu_checker (.*);
